### src/line_sensor_calibrate_and_steer_macros.svh
// Assertion helpers for the checker file lscs_checker.sv.
// Both expect i_clk and i_rst_n to be visible where they are used.
`ifndef LINE_SENSOR_CALIBRATE_AND_STEER_MACROS_SVH
`define LINE_SENSOR_CALIBRATE_AND_STEER_MACROS_SVH

// Same-cycle implication, skipped while reset is asserted.
`define LSCS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, skipped while reset is asserted.
`define LSCS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/lscs_pkg.sv
package lscs_pkg;

    // Sensor channel count
    localparam int NUM_CH = 8;

    // Duty word width
    localparam int SPEED_W = 8;
    typedef logic [SPEED_W-1:0] t_speed;

    // Frame commands
    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_SAMPLE = 2'd1,
        CMD_FINISH = 2'd2,
        CMD_TRACK  = 2'd3
    } t_cmd;

    // Configuration register indexes
    localparam logic [1:0] REG_SPEED_FAST   = 2'd0;
    localparam logic [1:0] REG_SPEED_SLOW   = 2'd1;
    localparam logic [1:0] REG_SPEED_SEARCH = 2'd2;

    // Duty reset values
    localparam t_speed RST_SPEED_FAST   = 8'd200;
    localparam t_speed RST_SPEED_SLOW   = 8'd120;
    localparam t_speed RST_SPEED_SEARCH = 8'd80;

    // Sensor groups within the line mask
    localparam logic [NUM_CH-1:0] MASK_CENTER = 8'h18;
    localparam logic [NUM_CH-1:0] MASK_LEFT   = 8'h07;
    localparam logic [NUM_CH-1:0] MASK_RIGHT  = 8'hE0;

endpackage

### src/line_sensor_calibrate_and_steer.sv
// An accepted word is held in the input register, then moves on to the result register;
// o_valid rises when it enters the result register, which it waits for while the result side stalls.
// Throughput: one word per cycle while the result side is not stalled; the per-channel
// compare, min/max and midpoint all fit between the input register and the result register.
// Reset (synchronous, i_rst_n low): both stages empty, max 0, min all ones, thresholds 0,
// duties back to 200/120/80. Config writes are taken every cycle (o_cfg_ready tied high).
module line_sensor_calibrate_and_steer #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // input words
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic [1:0]             i_command,
    input  logic [SAMPLE_BITS-1:0] i_sensor_0,
    input  logic [SAMPLE_BITS-1:0] i_sensor_1,
    input  logic [SAMPLE_BITS-1:0] i_sensor_2,
    input  logic [SAMPLE_BITS-1:0] i_sensor_3,
    input  logic [SAMPLE_BITS-1:0] i_sensor_4,
    input  logic [SAMPLE_BITS-1:0] i_sensor_5,
    input  logic [SAMPLE_BITS-1:0] i_sensor_6,
    input  logic [SAMPLE_BITS-1:0] i_sensor_7,
    // result words
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [7:0]             o_left_duty,
    output logic [7:0]             o_right_duty,
    output logic [7:0]             o_line_mask,
    // configuration writes
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [1:0]             i_cfg_index,
    input  logic [7:0]             i_cfg_data
);

    localparam int NCH = lscs_pkg::NUM_CH;

    // input stage
    logic                   r_in_valid;
    lscs_pkg::t_cmd         r_in_cmd;
    logic [SAMPLE_BITS-1:0] r_in_smp [NCH];
    logic [SAMPLE_BITS-1:0] w_smp    [NCH];

    // result stage
    logic                   r_out_valid;
    lscs_pkg::t_speed       r_out_left;
    lscs_pkg::t_speed       r_out_right;
    logic [NCH-1:0]         r_out_mask;

    // calibration state
    logic [SAMPLE_BITS-1:0] r_max [NCH];
    logic [SAMPLE_BITS-1:0] r_min [NCH];
    logic [SAMPLE_BITS-1:0] r_thr [NCH];
    logic [SAMPLE_BITS-1:0] n_max [NCH];
    logic [SAMPLE_BITS-1:0] n_min [NCH];
    logic [SAMPLE_BITS-1:0] n_thr [NCH];
    logic [SAMPLE_BITS:0]   w_sum [NCH];

    // duty registers
    lscs_pkg::t_speed       r_speed_fast;
    lscs_pkg::t_speed       r_speed_slow;
    lscs_pkg::t_speed       r_speed_search;

    logic                   w_accept;
    logic                   w_adv;
    logic [NCH-1:0]         n_mask;
    lscs_pkg::t_speed       n_left;
    lscs_pkg::t_speed       n_right;

    assign w_smp[0] = i_sensor_0;
    assign w_smp[1] = i_sensor_1;
    assign w_smp[2] = i_sensor_2;
    assign w_smp[3] = i_sensor_3;
    assign w_smp[4] = i_sensor_4;
    assign w_smp[5] = i_sensor_5;
    assign w_smp[6] = i_sensor_6;
    assign w_smp[7] = i_sensor_7;

    // handshake: the input stage moves on whenever the result register is empty or its word is being taken
    assign w_adv       = r_in_valid && (!r_out_valid || !i_stall);
    assign o_stall     = r_in_valid && !w_adv;
    assign w_accept    = i_valid && !o_stall;
    assign o_valid     = r_out_valid;
    assign o_cfg_ready = 1'b1;

    assign o_left_duty  = r_out_left;
    assign o_right_duty = r_out_right;
    assign o_line_mask  = r_out_mask;

    // per-channel calibration update and line detect
    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            w_sum[i] = {1'b0, r_max[i]} + {1'b0, r_min[i]};
            n_max[i] = r_max[i];
            n_min[i] = r_min[i];
            n_thr[i] = r_thr[i];
            n_mask[i] = 1'b0;
            unique case (r_in_cmd)
                lscs_pkg::CMD_START: begin
                    n_max[i] = r_in_smp[i];
                    n_min[i] = r_in_smp[i];
                end
                lscs_pkg::CMD_SAMPLE: begin
                    if (r_in_smp[i] > r_max[i]) begin
                        n_max[i] = r_in_smp[i];
                    end
                    if (r_in_smp[i] < r_min[i]) begin
                        n_min[i] = r_in_smp[i];
                    end
                end
                lscs_pkg::CMD_FINISH: begin
                    n_thr[i] = w_sum[i][SAMPLE_BITS:1];
                end
                lscs_pkg::CMD_TRACK: begin
                    n_mask[i] = (r_in_smp[i] > r_thr[i]);
                end
            endcase
        end
    end

    // steering priority
    always_comb begin
        n_left  = '0;
        n_right = '0;
        if (r_in_cmd == lscs_pkg::CMD_TRACK) begin
            priority if ((n_mask & lscs_pkg::MASK_CENTER) == lscs_pkg::MASK_CENTER) begin
                n_left  = r_speed_fast;
                n_right = r_speed_fast;
            end else if ((n_mask & lscs_pkg::MASK_LEFT) != '0) begin
                n_left  = r_speed_slow;
                n_right = r_speed_fast;
            end else if ((n_mask & lscs_pkg::MASK_RIGHT) != '0) begin
                n_left  = r_speed_fast;
                n_right = r_speed_slow;
            end else begin
                n_left  = r_speed_search;
                n_right = r_speed_search;
            end
        end
    end

    // stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // input payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cmd <= lscs_pkg::t_cmd'(i_command);
            for (int i = 0; i < NCH; i++) begin
                r_in_smp[i] <= w_smp[i];
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_left  <= n_left;
            r_out_right <= n_right;
            r_out_mask  <= n_mask;
        end
    end

    // calibration state, committed as the word leaves the input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCH; i++) begin
                r_max[i] <= '0;
                r_min[i] <= '1;
                r_thr[i] <= '0;
            end
        end else if (w_adv) begin
            for (int i = 0; i < NCH; i++) begin
                r_max[i] <= n_max[i];
                r_min[i] <= n_min[i];
                r_thr[i] <= n_thr[i];
            end
        end
    end

    // duty registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_fast   <= lscs_pkg::RST_SPEED_FAST;
            r_speed_slow   <= lscs_pkg::RST_SPEED_SLOW;
            r_speed_search <= lscs_pkg::RST_SPEED_SEARCH;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                lscs_pkg::REG_SPEED_FAST:   r_speed_fast   <= i_cfg_data;
                lscs_pkg::REG_SPEED_SLOW:   r_speed_slow   <= i_cfg_data;
                lscs_pkg::REG_SPEED_SEARCH: r_speed_search <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

endmodule

### src/lscs_checker.sv
`include "line_sensor_calibrate_and_steer_macros.svh"

module lscs_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_stall,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_left_duty,
    input logic [7:0] o_right_duty,
    input logic [7:0] o_line_mask
);

    logic w_center_both;
    logic w_center_only_one;

    assign w_center_both     = o_line_mask[3] && o_line_mask[4];
    assign w_center_only_one = (o_line_mask[2:0] == 3'b000) && (o_line_mask[7:5] == 3'b000)
                               && !w_center_both;

    // a stalled result word holds
    `LSCS_ASSERT_NEXT(a_out_hold, o_valid && i_stall,
        o_valid && $stable(o_left_duty) && $stable(o_right_duty) && $stable(o_line_mask),
        "result word changed while stalled")

    // input side only backs up when the result side is blocked
    `LSCS_ASSERT_NOW(a_stall_cause, o_stall, o_valid && i_stall,
        "input stalled with result side free")

    // both centre sensors on line drive both wheels alike
    `LSCS_ASSERT_NOW(a_center_straight, o_valid && w_center_both,
        o_left_duty == o_right_duty, "centre pair did not give equal duties")

    // no outer sensor and not both centres: search or idle, both wheels alike
    `LSCS_ASSERT_NOW(a_search_equal, o_valid && w_center_only_one,
        o_left_duty == o_right_duty, "search duties differ")

endmodule

bind line_sensor_calibrate_and_steer lscs_checker u_lscs_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_left_duty  (o_left_duty),
    .o_right_duty (o_right_duty),
    .o_line_mask  (o_line_mask)
);
